### rtl/flptm_pkg.sv
`default_nettype none
package flptm_pkg;

  localparam int unsigned AddrW = 52;
  localparam int unsigned VaW   = 48;
  localparam int unsigned IdxW  = 9;
  localparam int unsigned EntW  = 64;

  localparam logic [1:0] ModeTranslate = 2'd0;
  localparam logic [1:0] ModeMap4k     = 2'd1;
  localparam logic [1:0] ModeUnmap     = 2'd2;
  localparam logic [1:0] ModeMap2m     = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoMap = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic [63:0] AddrMask = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] Mask2m   = 64'h000F_FFFF_FFE0_0000;
  localparam logic [63:0] FlP      = 64'h1;
  localparam logic [63:0] FlW      = 64'h2;
  localparam logic [63:0] FlU      = 64'h4;
  localparam logic [63:0] FlPs     = 64'h80;
  localparam logic [63:0] FlKeep   = 64'h1F;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_WAIT,
    S_EVAL,
    S_CLEAR,
    S_SPLIT,
    S_OUT
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic       start;
    logic       eval;
    logic       clr_step;
    logic       split_step;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       done;
    logic       need_clear;
    logic       need_split;
    logic       sweep_last;
  } sts_t;

endpackage
`default_nettype wire

### rtl/flptm_if.sv
`default_nettype none
interface flptm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [47:0] virt_addr;
  logic [51:0] phys_addr;
  logic [11:0] page_flags;
  modport source (output valid, mode, virt_addr, phys_addr, page_flags, input ready);
  modport sink (input valid, mode, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface flptm_rsp_if;
  logic        valid;
  logic        ready;
  logic [51:0] result_addr;
  logic [1:0]  status;
  modport source (output valid, result_addr, status, input ready);
  modport sink (input valid, result_addr, status, output ready);
endinterface
`default_nettype wire

### rtl/flptm_ctrl.sv
`default_nettype none
module flptm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_fire,
  input  wire flptm_pkg::sts_t sts,
  output flptm_pkg::cmd_t     cmd,
  output logic                busy,
  output logic                out_valid
);

  flptm_pkg::state_t state_r, state_nxt;

  // State register; reset starts the sweep that clears the root frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flptm_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      flptm_pkg::S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = flptm_pkg::S_IDLE;
        end
      end
      flptm_pkg::S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = flptm_pkg::S_READ;
        end
      end
      flptm_pkg::S_READ: begin
        state_nxt = flptm_pkg::S_WAIT;
      end
      flptm_pkg::S_WAIT: begin
        state_nxt = flptm_pkg::S_EVAL;
      end
      flptm_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.done) begin
          state_nxt = flptm_pkg::S_OUT;
        end else if (sts.need_split) begin
          state_nxt = flptm_pkg::S_SPLIT;
        end else if (sts.need_clear) begin
          state_nxt = flptm_pkg::S_CLEAR;
        end else begin
          state_nxt = flptm_pkg::S_READ;
        end
      end
      flptm_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = flptm_pkg::S_READ;
        end
      end
      flptm_pkg::S_SPLIT: begin
        cmd.split_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = flptm_pkg::S_READ;
        end
      end
      flptm_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_nxt = flptm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = flptm_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/flptm_dp.sv
`default_nettype none
module flptm_dp #(
  parameter int unsigned TABLE_FRAMES = 16,
  parameter int unsigned FW = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire flptm_pkg::cmd_t cmd,
  output flptm_pkg::sts_t     sts,
  input  wire logic           cfg_write_en,
  input  wire logic [51:0]    cfg_write_data,
  input  wire logic [1:0]     req_mode,
  input  wire logic [47:0]    req_va,
  input  wire logic [51:0]    req_pa,
  input  wire logic [11:0]    req_flags,
  output logic [51:0]         res_addr,
  output logic [1:0]          res_status
);

  localparam int unsigned AW = FW + flptm_pkg::IdxW;
  localparam int unsigned CW = FW + 1;

  // Table frame memory; the root frame is cleared by a sweep after reset.
  logic [63:0] mem [TABLE_FRAMES*512];

  logic [51:0] base_r;
  logic [CW-1:0] nff_r;
  logic [1:0]  mode_r;
  logic [47:0] va_r;
  logic [51:0] pa_r;
  logic [11:0] fl_r;
  logic [1:0]  lvl_r;
  logic [FW-1:0] tbl_r;
  logic [51:0] addr_r;
  logic [1:0]  st_r;
  logic [63:0] rd_q;
  logic [8:0]  sw_r;
  logic [FW-1:0] swf_r;
  logic [63:0] sbase_r;
  logic [63:0] sfl_r;

  logic        wr_en;
  logic [AW-1:0] wr_a;
  logic [63:0] wr_d;
  logic [AW-1:0] rd_a;
  logic [63:0] ent;

  logic [8:0] idx;
  always_comb begin
    case (lvl_r)
      2'd0: idx = va_r[47:39];
      2'd1: idx = va_r[38:30];
      2'd2: idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end
  assign rd_a = {tbl_r, idx};

  // Registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rd_q <= mem[rd_a];
  end
  assign ent = rd_q;

  // Pointer follow check.
  logic [51:0] off;
  logic [39:0] kk;
  logic        fol_ok;
  assign off = ent[51:0] & flptm_pkg::AddrMask[51:0];
  assign kk = 40'((off - base_r) >> 12);
  assign fol_ok = (kk < 40'(nff_r)) && (kk < 40'(TABLE_FRAMES));

  logic full;
  logic [51:0] nf_addr;
  assign full = (nff_r >= CW'(TABLE_FRAMES));
  assign nf_addr = (base_r + {nff_r[FW-1:0], 12'h000}) &
                   flptm_pkg::AddrMask[51:0];

  logic mapping;
  logic [63:0] user;
  assign mapping = (mode_r == flptm_pkg::ModeMap4k) || (mode_r == flptm_pkg::ModeMap2m);
  assign user = (mode_r == flptm_pkg::ModeMap4k) ? (64'(fl_r) & flptm_pkg::FlU) : 64'd0;

  logic [63:0] e2;
  logic        ev_done;
  logic        ev_clear;
  logic        ev_split;
  logic [51:0] ev_addr;
  logic [1:0]  ev_st;
  logic        ev_adv;

  // Evaluate one level of the walk.
  always_comb begin
    ev_done = 1'b0; ev_clear = 1'b0; ev_split = 1'b0; ev_adv = 1'b0;
    ev_addr = 52'd0; ev_st = flptm_pkg::StOk;
    wr_en = 1'b0; wr_a = rd_a; wr_d = 64'd0; e2 = ent;
    if (cmd.eval) begin
      if (mode_r == flptm_pkg::ModeTranslate) begin
        if (!ent[0]) begin
          ev_done = 1'b1; ev_st = flptm_pkg::StNoMap;
        end else if (lvl_r == 2'd3) begin
          ev_done = 1'b1;
          ev_addr = ent[51:0] & flptm_pkg::AddrMask[51:0] | {40'd0, va_r[11:0]};
        end else if (lvl_r == 2'd2 && ent[7]) begin
          ev_done = 1'b1;
          ev_addr = ent[51:0] & flptm_pkg::Mask2m[51:0] | {31'd0, va_r[20:0]};
        end else if (!fol_ok) begin
          ev_done = 1'b1; ev_st = flptm_pkg::StNoMap;
        end else begin
          ev_adv = 1'b1;
        end
      end else if (lvl_r == 2'd3) begin
        ev_done = 1'b1;
        wr_en = 1'b1;
        wr_d = (mode_r == flptm_pkg::ModeMap4k) ?
               ((64'(pa_r) & flptm_pkg::AddrMask) | 64'(fl_r) | flptm_pkg::FlP) : 64'd0;
      end else if (lvl_r == 2'd2 && mode_r == flptm_pkg::ModeMap2m) begin
        ev_done = 1'b1;
        wr_en = 1'b1;
        wr_d = (64'(va_r) & flptm_pkg::Mask2m) | (64'(fl_r) & 64'h1E) |
               flptm_pkg::FlP | flptm_pkg::FlPs;
      end else if (lvl_r == 2'd2 && ent[0] && ent[7]) begin
        if (!mapping) begin
          ev_done = 1'b1; ev_st = flptm_pkg::StNoMap;
        end else if (full) begin
          ev_done = 1'b1; ev_st = flptm_pkg::StFull;
        end else begin
          ev_split = 1'b1;
          wr_en = 1'b1;
          wr_d = 64'(nf_addr) | flptm_pkg::FlP | flptm_pkg::FlW | (ent & flptm_pkg::FlU);
        end
      end else if (!ent[0]) begin
        if (!mapping) begin
          ev_done = 1'b1; ev_st = flptm_pkg::StNoMap;
        end else if (full) begin
          ev_done = 1'b1; ev_st = flptm_pkg::StFull;
        end else begin
          ev_clear = 1'b1;
          wr_en = 1'b1;
          wr_d = 64'(nf_addr) | flptm_pkg::FlP | flptm_pkg::FlW | user;
        end
      end else begin
        e2 = ent | user;
        if (user != 64'd0) begin
          wr_en = 1'b1; wr_d = e2;
        end
        if (fol_ok) ev_adv = 1'b1;
        else begin
          ev_done = 1'b1; ev_st = flptm_pkg::StNoMap;
        end
      end
    end else if (cmd.clr_step) begin
      wr_en = 1'b1; wr_a = {swf_r, sw_r}; wr_d = 64'd0;
    end else if (cmd.split_step) begin
      wr_en = 1'b1; wr_a = {swf_r, sw_r};
      wr_d = ((sbase_r + {43'd0, sw_r, 12'h000}) & 64'h000F_FFFF_FFFF_FFFF) |
             sfl_r | flptm_pkg::FlP;
    end
  end

  assign sts.done = ev_done;
  assign sts.need_clear = ev_clear;
  assign sts.need_split = ev_split;
  assign sts.sweep_last = (sw_r == 9'h1FF);

  // Request and walk registers; the sweep pointer starts on the root frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      nff_r <= CW'(1);
      sw_r <= '0;
      swf_r <= '0;
    end else begin
      if (cfg_write_en) base_r <= cfg_write_data & flptm_pkg::AddrMask[51:0];
      if (ev_clear || ev_split) nff_r <= nff_r + CW'(1);
      if (ev_clear || ev_split) begin
        sw_r <= '0; swf_r <= nff_r[FW-1:0];
        sbase_r <= ent & flptm_pkg::Mask2m;
        sfl_r <= ent & flptm_pkg::FlKeep;
      end else if (cmd.clr_step || cmd.split_step) begin
        sw_r <= sw_r + 9'd1;
      end
    end
    if (cmd.start) begin
      mode_r <= req_mode; va_r <= req_va; pa_r <= req_pa; fl_r <= req_flags;
      lvl_r <= 2'd0; tbl_r <= '0;
    end
    if (ev_done) begin
      addr_r <= ev_addr; st_r <= ev_st;
    end
    if (ev_adv) begin
      lvl_r <= lvl_r + 2'd1; tbl_r <= kk[FW-1:0];
    end
  end

  assign res_addr = addr_r;
  assign res_status = st_r;

endmodule
`default_nettype wire

### rtl/four_level_page_table_manager.sv
`default_nettype none
// Four-level page-table manager. After reset the root table frame is cleared
// one entry per cycle, so the request input stays not ready until that sweep
// is done. One request is taken at a time; the controller re-reads the level
// it just changed, and each level passes through the read, wait and evaluate
// states on the single table memory with its registered read. A map that
// creates levels clears each new table frame (and fills a split 2 MiB page)
// one entry per cycle.
module four_level_page_table_manager #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_en,
  input  wire logic [51:0] cfg_write_data,
  flptm_req_if.sink        in_req,
  flptm_rsp_if.source      out_rsp
);

  localparam int unsigned FW = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;

  flptm_pkg::cmd_t cmd;
  flptm_pkg::sts_t sts;
  logic busy;
  logic in_fire;
  logic out_fire;

  assign in_req.ready = !busy;
  assign in_fire = in_req.valid && !busy;
  assign out_fire = out_rsp.valid && out_rsp.ready;

  flptm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_rsp.valid)
  );

  flptm_dp #(.TABLE_FRAMES(TABLE_FRAMES), .FW(FW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .req_mode(in_req.mode), .req_va(in_req.virt_addr),
    .req_pa(in_req.phys_addr), .req_flags(in_req.page_flags),
    .res_addr(out_rsp.result_addr), .res_status(out_rsp.status)
  );

endmodule
`default_nettype wire
